// ===== src/istft_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Inverse STFT synthesis package
// Shared sizes, word types, state codes and the constant twiddle and window
// tables built at elaboration.
// ----------------------------------------------------------------------------
package istft_pkg;

   localparam int FFT_SIZE = 256;
   localparam int HALF_N   = FFT_SIZE / 2;
   localparam int QUART_N  = FFT_SIZE / 4;
   localparam int NUM_BINS = HALF_N + 1;
   localparam int LOG2_N   = $clog2(FFT_SIZE);
   localparam int ACC_AW   = $clog2(FFT_SIZE);
   localparam int BIN_AW   = $clog2(NUM_BINS);
   localparam int BEATS    = 2 * (HALF_N - 1);
   localparam int BEAT_W   = $clog2(BEATS);
   localparam int TW_FRAC  = 22;
   localparam int ROUND_SH = TW_FRAC + LOG2_N;
   localparam int WIN_FRAC = 23;

   localparam longint unsigned PI_Q30 = 64'd3373259426;
   localparam longint ONE_Q30 = 64'sd1073741824;

   localparam logic CSR_HOP_SIZE      = 1'b0;
   localparam logic CSR_SIGNAL_LENGTH = 1'b1;

   localparam logic [6:0] HOP_MAX   = 7'd64;
   localparam logic [6:0] HOP_RESET = 7'd64;

   typedef logic [FFT_SIZE-1:0][23:0] tw_tab_type;
   typedef logic [FFT_SIZE-1:0][22:0] win_tab_type;

   typedef struct packed {
      logic signed [31:0] re;
      logic signed [31:0] im;
      logic [BIN_AW-1:0]  idx;
      logic               last;
   } bin_item_type;

   typedef struct packed {
      logic signed [23:0] sample;
      logic               final_sample;
   } out_item_type;

   typedef enum logic [3:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_INIT,
      BK_DFT,
      BK_DRAIN,
      BK_ROUND,
      BK_WIN,
      BK_ADD,
      BK_EMIT_RD,
      BK_EMIT_CALC,
      BK_EMIT_OUT
   } back_state_type;

   function automatic longint sin_q30(input int a);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint sum;
      x = (64'd2 * PI_Q30 * 64'(a) + 64'(HALF_N)) / 64'(FFT_SIZE);
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int i = 1; i <= 8; i++) begin
         term = (term * x2) >> 30;
         term = term / 64'(2 * i * (2 * i + 1));
         if ((i & 1) != 0) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      if (sum > ONE_Q30) begin
         sum = ONE_Q30;
      end
      return sum;
   endfunction

   function automatic tw_tab_type build_tw(input bit want_sin);
      longint mag [QUART_N+1];
      tw_tab_type tab;
      int quad;
      int r;
      longint cm;
      longint sm;
      longint cs;
      longint ss;
      for (int a = 0; a <= QUART_N; a++) begin
         mag[a] = sin_q30(a);
      end
      for (int k = 0; k < FFT_SIZE; k++) begin
         quad = k / QUART_N;
         r = k % QUART_N;
         case (quad)
            0: begin
               cm = mag[QUART_N - r]; cs = 1;  sm = mag[r];           ss = 1;
            end
            1: begin
               cm = mag[r];           cs = -1; sm = mag[QUART_N - r]; ss = 1;
            end
            2: begin
               cm = mag[QUART_N - r]; cs = -1; sm = mag[r];           ss = -1;
            end
            default: begin
               cm = mag[r];           cs = 1;  sm = mag[QUART_N - r]; ss = -1;
            end
         endcase
         if (want_sin) begin
            tab[k] = 24'(ss * ((sm + 128) >>> 8));
         end else begin
            tab[k] = 24'(cs * ((cm + 128) >>> 8));
         end
      end
      return tab;
   endfunction

   function automatic win_tab_type build_win();
      longint mag [QUART_N+1];
      win_tab_type tab;
      int quad;
      int r;
      longint c30;
      longint w;
      for (int a = 0; a <= QUART_N; a++) begin
         mag[a] = sin_q30(a);
      end
      for (int k = 0; k < FFT_SIZE; k++) begin
         quad = k / QUART_N;
         r = k % QUART_N;
         case (quad)
            0:       c30 = mag[QUART_N - r];
            1:       c30 = -mag[r];
            2:       c30 = -mag[QUART_N - r];
            default: c30 = mag[r];
         endcase
         w = (ONE_Q30 - c30 + 128) >>> 8;
         if (w > 8388607) begin
            w = 8388607;
         end
         tab[k] = 23'(w);
      end
      return tab;
   endfunction

   localparam tw_tab_type  COS_TAB = build_tw(1'b0);
   localparam tw_tab_type  SIN_TAB = build_tw(1'b1);
   localparam win_tab_type WIN_TAB = build_win();

endpackage
`default_nettype wire

// ===== src/istft_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Small word queue
// Register-based first-in first-out queue with the oldest word shown ahead.
// ----------------------------------------------------------------------------
module istft_fifo #(
   parameter int WIDTH      = 8,
   parameter int DEPTH_LOG2 = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int DEPTH = 2 ** DEPTH_LOG2;

   logic [WIDTH-1:0]      mem_ff [DEPTH];
   logic [DEPTH_LOG2-1:0] wptr_ff, wptr_in;
   logic [DEPTH_LOG2-1:0] rptr_ff, rptr_in;
   logic [DEPTH_LOG2:0]   count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign full    = (count_ff == (DEPTH_LOG2+1)'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rptr_ff];

   always_comb begin
      wptr_in  = do_push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = do_pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wptr_ff] <= wr_data;
      end
   end

endmodule
`default_nettype wire

// ===== src/istft_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Inverse STFT front end
// Numbers incoming bins within the frame, drops the imaginary part of the DC
// and Nyquist bins and marks the last bin of each frame.
// ----------------------------------------------------------------------------
module istft_front
   import istft_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic signed [31:0] bin_real,
   input  logic signed [31:0] bin_imag,
   output logic               q_push,
   output bin_item_type       q_item
);

   logic [BIN_AW-1:0] bin_count_ff, bin_count_in;
   logic              is_last;
   logic              no_imag;

   assign is_last = (bin_count_ff == BIN_AW'(NUM_BINS - 1));
   assign no_imag = (bin_count_ff == '0) || (bin_count_ff == BIN_AW'(HALF_N));

   always_comb begin
      q_push      = accept;
      q_item.re   = bin_real;
      q_item.im   = no_imag ? 32'sd0 : bin_imag;
      q_item.idx  = bin_count_ff;
      q_item.last = is_last;
      bin_count_in = bin_count_ff;
      if (accept) begin
         bin_count_in = is_last ? '0 : bin_count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_count_ff <= '0;
      end else begin
         bin_count_ff <= bin_count_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/istft_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Inverse STFT back end
// Stores the bins of a frame, runs the inverse real DFT on one shared
// multiply-accumulate unit, windows and overlap-adds into the accumulator
// memory, then finishes the hop oldest samples, emitting those in the signal.
// ----------------------------------------------------------------------------
module istft_back
   import istft_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic [6:0]   hop_size,
   input  logic [31:0]  signal_length,
   input  logic         q_empty,
   input  bin_item_type q_item,
   output logic         q_pop,
   input  logic         out_full,
   output logic         out_push,
   output out_item_type out_item,
   output logic         clearing
);

   localparam logic [28:0] RECIP_6 = 29'd357913942;
   localparam logic signed [31:0] A_HI = 32'sd12582910;
   localparam logic signed [31:0] A_LO = -32'sd12582912;

   back_state_type state_ff, state_in;

   logic [63:0]        bin_mem_ff [NUM_BINS];
   logic signed [31:0] acc_mem_ff [FFT_SIZE];

   logic [ACC_AW-1:0]  clr_ff, clr_in;
   logic [ACC_AW-1:0]  n_ff, n_in;
   logic [BEAT_W-1:0]  beat_ff, beat_in;
   logic [ACC_AW-1:0]  tw_ff, tw_in;
   logic               v1_ff, v1_in, ph1_ff, ph1_in;
   logic [ACC_AW-1:0]  tw1_ff, tw1_in;
   logic               v2_ff, v2_in, ph2_ff, ph2_in;
   logic [63:0]        bin_rd_ff;
   logic signed [55:0] prod_ff, prod_in;
   logic signed [63:0] sum_ff, sum_in;
   logic signed [33:0] x_ff, x_in;
   logic signed [57:0] wprod_ff, wprod_in;
   logic signed [31:0] acc_q_ff;
   logic [56:0]        dprod_ff, dprod_in;
   logic               emit_ff, emit_in;
   logic [5:0]         j_ff, j_in;
   logic [6:0]         hop_ff, hop_in;
   logic [ACC_AW-1:0]  base_ff, base_in;
   logic [12:0]        start_ff, start_in;
   logic               big_ff, big_in;
   logic [31:0]        frame_ff, frame_in;
   logic [31:0]        sent_ff, sent_in;
   logic signed [31:0] dc_ff, dc_in, nyq_ff, nyq_in;

   logic               acc_we;
   logic [ACC_AW-1:0]  acc_wa, acc_ra;
   logic signed [31:0] acc_wd;
   logic               bin_we;
   logic [BIN_AW-1:0]  bin_ra;

   logic [6:0]         hop_c;
   logic [14:0]        base_prod;
   logic signed [32:0] dsum;
   logic signed [55:0] op_mul;
   logic signed [23:0] tw_mul;
   logic signed [34:0] y;
   logic signed [35:0] t;
   logic signed [24:0] a_cl;
   logic signed [29:0] mp_s;
   logic               centred;

   assign clearing = (state_ff == BK_CLEAR);
   assign bin_ra   = BIN_AW'(beat_ff[BEAT_W-1:1]) + 1'b1;
   assign hop_c    = (hop_size == '0) ? 7'd1 : ((hop_size > HOP_MAX) ? HOP_MAX : hop_size);
   assign base_prod = frame_ff[7:0] * hop_c;
   assign dsum     = 33'(dc_ff) + (n_ff[0] ? -33'(nyq_ff) : 33'(nyq_ff));

   // Shared multiplier stage of the transform loop.
   assign op_mul  = ph1_ff ? 56'($signed(bin_rd_ff[31:0])) : 56'($signed(bin_rd_ff[63:32]));
   assign tw_mul  = ph1_ff ? $signed(SIN_TAB[tw1_ff]) : $signed(COS_TAB[tw1_ff]);
   assign prod_in = op_mul * 56'(tw_mul);
   assign v1_in   = (state_ff == BK_DFT);
   assign ph1_in  = beat_ff[0];
   assign tw1_in  = tw_ff;
   assign v2_in   = v1_ff;
   assign ph2_in  = ph1_ff;

   assign y = 35'((wprod_ff + (58'sd1 <<< (WIN_FRAC - 1))) >>> WIN_FRAC);
   assign t = 36'(acc_q_ff) + 36'(y);
   assign a_cl = (acc_q_ff > A_HI) ? 25'(A_HI) : ((acc_q_ff < A_LO) ? 25'(A_LO) : 25'(acc_q_ff));
   assign mp_s = (30'(a_cl) <<< 2) + 30'sd201326595;
   assign centred = !big_ff && ((14'(start_ff) + 14'(j_ff)) < 14'(HALF_N));

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      n_in     = n_ff;
      beat_in  = beat_ff;
      tw_in    = tw_ff;
      sum_in   = sum_ff;
      x_in     = x_ff;
      wprod_in = wprod_ff;
      dprod_in = dprod_ff;
      emit_in  = emit_ff;
      j_in     = j_ff;
      hop_in   = hop_ff;
      base_in  = base_ff;
      start_in = start_ff;
      big_in   = big_ff;
      frame_in = frame_ff;
      sent_in  = sent_ff;
      dc_in    = dc_ff;
      nyq_in   = nyq_ff;
      q_pop    = 1'b0;
      bin_we   = 1'b0;
      acc_we   = 1'b0;
      acc_wa   = base_ff + n_ff;
      acc_wd   = 32'sd0;
      acc_ra   = base_ff + n_ff;
      out_push = 1'b0;
      out_item.sample       = $signed(dprod_ff[54:31]);
      out_item.final_sample = (sent_ff == signal_length - 32'd1);

      if (v2_ff) begin
         if (ph2_ff) begin
            sum_in = sum_ff - (64'(prod_ff) <<< 1);
         end else begin
            sum_in = sum_ff + (64'(prod_ff) <<< 1);
         end
      end

      case (state_ff)
         BK_CLEAR: begin
            acc_we = 1'b1;
            acc_wa = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == ACC_AW'(FFT_SIZE - 1)) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               bin_we = 1'b1;
               if (q_item.idx == '0) begin
                  dc_in = q_item.re;
               end
               if (q_item.last) begin
                  nyq_in   = q_item.re;
                  hop_in   = hop_c;
                  base_in  = base_prod[ACC_AW-1:0];
                  start_in = 13'(frame_ff[6:0]) * 13'(hop_c);
                  big_in   = |frame_ff[31:7];
                  n_in     = '0;
                  state_in = BK_INIT;
               end
            end
         end
         BK_INIT: begin
            sum_in   = 64'(dsum) <<< TW_FRAC;
            beat_in  = '0;
            tw_in    = n_ff;
            state_in = BK_DFT;
         end
         BK_DFT: begin
            beat_in = beat_ff + 1'b1;
            if (beat_ff[0]) begin
               tw_in = tw_ff + n_ff;
            end
            if (beat_ff == BEAT_W'(BEATS - 1)) begin
               state_in = BK_DRAIN;
            end
         end
         BK_DRAIN: begin
            if (!v1_ff && !v2_ff) begin
               state_in = BK_ROUND;
            end
         end
         BK_ROUND: begin
            x_in     = 34'((sum_ff + (64'sd1 <<< (ROUND_SH - 1))) >>> ROUND_SH);
            state_in = BK_WIN;
         end
         BK_WIN: begin
            wprod_in = 58'(x_ff) * 58'($signed({1'b0, WIN_TAB[n_ff]}));
            state_in = BK_ADD;
         end
         BK_ADD: begin
            acc_we = 1'b1;
            if (t > 36'sd2147483647) begin
               acc_wd = 32'sh7fffffff;
            end else if (t < -36'sd2147483648) begin
               acc_wd = 32'sh80000000;
            end else begin
               acc_wd = t[31:0];
            end
            n_in = n_ff + 1'b1;
            if (n_ff == ACC_AW'(FFT_SIZE - 1)) begin
               j_in     = '0;
               state_in = BK_EMIT_RD;
            end else begin
               state_in = BK_INIT;
            end
         end
         BK_EMIT_RD: begin
            acc_ra   = base_ff + ACC_AW'(j_ff);
            state_in = BK_EMIT_CALC;
         end
         BK_EMIT_CALC: begin
            acc_we   = 1'b1;
            acc_wa   = base_ff + ACC_AW'(j_ff);
            dprod_in = 57'(mp_s[27:0]) * 57'(RECIP_6);
            emit_in  = !centred && (sent_ff < signal_length);
            state_in = BK_EMIT_OUT;
         end
         BK_EMIT_OUT: begin
            if (!emit_ff || !out_full) begin
               if (emit_ff) begin
                  out_push = 1'b1;
                  sent_in  = sent_ff + 32'd1;
               end
               if (7'(j_ff) == hop_ff - 7'd1) begin
                  frame_in = frame_ff + 32'd1;
                  state_in = BK_IDLE;
               end else begin
                  j_in     = j_ff + 1'b1;
                  state_in = BK_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_CLEAR;
         clr_ff   <= '0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         frame_ff <= '0;
         sent_ff  <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         v1_ff    <= v1_in;
         v2_ff    <= v2_in;
         frame_ff <= frame_in;
         sent_ff  <= sent_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      beat_ff  <= beat_in;
      tw_ff    <= tw_in;
      ph1_ff   <= ph1_in;
      tw1_ff   <= tw1_in;
      ph2_ff   <= ph2_in;
      prod_ff  <= prod_in;
      sum_ff   <= sum_in;
      x_ff     <= x_in;
      wprod_ff <= wprod_in;
      dprod_ff <= dprod_in;
      emit_ff  <= emit_in;
      j_ff     <= j_in;
      hop_ff   <= hop_in;
      base_ff  <= base_in;
      start_ff <= start_in;
      big_ff   <= big_in;
      dc_ff    <= dc_in;
      nyq_ff   <= nyq_in;
   end

   always_ff @(posedge clock) begin
      if (bin_we) begin
         bin_mem_ff[q_item.idx] <= {q_item.re, q_item.im};
      end
      bin_rd_ff <= bin_mem_ff[bin_ra];
   end

   always_ff @(posedge clock) begin
      if (acc_we) begin
         acc_mem_ff[acc_wa] <= acc_wd;
      end
      acc_q_ff <= acc_mem_ff[acc_ra];
   end

endmodule
`default_nettype wire

// ===== src/stft_overlap_add_synthesis_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Inverse STFT overlap-add synthesis
// Push spectrum bins 0 to N/2 of each frame in order on the req_ channel
// (one word per bin); reconstructed Q1.23 samples come out on the rsp_
// channel, oldest first, shown while rsp_empty is low and taken with rsp_pop.
// hop_size and signal_length are written through the csr_ port while idle.
// A bin is taken and queued; the last bin of a frame starts the transform,
// which runs on one shared multiplier, one cosine and one sine product per bin.
// Finishing then steps through read, calculate and output states for each
// hop sample, so throughput is set by the transform loop.
// After reset the block clears the overlap accumulator, holding req_full
// high meanwhile. If the receiver stops popping, finished samples fill the
// output queue, the back end waits, and req_full rises once the bin queue
// is full; no word is lost.
// ----------------------------------------------------------------------------
module stft_overlap_add_synthesis_top
   import istft_pkg::*;
#(
   parameter int QUEUE_DEPTH_LOG2 = 2,
   parameter int OUT_DEPTH_LOG2   = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic signed [31:0] req_bin_real,
   input  logic signed [31:0] req_bin_imag,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic signed [23:0] rsp_sample,
   output logic               rsp_final_sample,
   input  logic               csr_wr_en,
   input  logic               csr_index,
   input  logic [31:0]        csr_wdata
);

   logic [6:0]   hop_size_ff;
   logic [31:0]  signal_length_ff;
   logic         accept;
   logic         q_push, q_full, q_pop, q_empty;
   bin_item_type q_wr_item, q_rd_item;
   logic         out_push, out_full;
   out_item_type out_wr_item, out_rd_item;
   logic         clearing;

   assign req_full         = q_full || clearing;
   assign accept           = req_push && !req_full;
   assign rsp_sample       = out_rd_item.sample;
   assign rsp_final_sample = out_rd_item.final_sample;

   always_ff @(posedge clock) begin
      if (reset) begin
         hop_size_ff      <= HOP_RESET;
         signal_length_ff <= '0;
      end else if (csr_wr_en) begin
         if (csr_index == CSR_HOP_SIZE) begin
            hop_size_ff <= csr_wdata[6:0];
         end
         if (csr_index == CSR_SIGNAL_LENGTH) begin
            signal_length_ff <= csr_wdata;
         end
      end
   end

   istft_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .bin_real (req_bin_real),
      .bin_imag (req_bin_imag),
      .q_push   (q_push),
      .q_item   (q_wr_item)
   );

   istft_fifo #(
      .WIDTH      ($bits(bin_item_type)),
      .DEPTH_LOG2 (QUEUE_DEPTH_LOG2)
   ) u_bin_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (q_wr_item),
      .full    (q_full),
      .pop     (q_pop),
      .rd_data (q_rd_item),
      .empty   (q_empty)
   );

   istft_back u_back (
      .clock         (clock),
      .reset         (reset),
      .hop_size      (hop_size_ff),
      .signal_length (signal_length_ff),
      .q_empty       (q_empty),
      .q_item        (q_rd_item),
      .q_pop         (q_pop),
      .out_full      (out_full),
      .out_push      (out_push),
      .out_item      (out_wr_item),
      .clearing      (clearing)
   );

   istft_fifo #(
      .WIDTH      ($bits(out_item_type)),
      .DEPTH_LOG2 (OUT_DEPTH_LOG2)
   ) u_out_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (out_push),
      .wr_data (out_wr_item),
      .full    (out_full),
      .pop     (rsp_pop),
      .rd_data (out_rd_item),
      .empty   (rsp_empty)
   );

endmodule
`default_nettype wire

// ===== src/istft_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Inverse STFT port checker
// Watches the top-level ports for reset behaviour and result word stability.
// ----------------------------------------------------------------------------
module istft_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_full,
   input logic               rsp_empty,
   input logic               rsp_pop,
   input logic signed [23:0] rsp_sample,
   input logic               rsp_final_sample
);

   a_empty_after_reset : assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   a_full_while_clearing : assert property (@(posedge clock)
      reset |=> req_full)
      else $error("input accepted before the accumulator was cleared");

   a_word_held : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty)
      else $error("waiting result word withdrawn");

   a_word_stable : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> ($stable(rsp_sample) && $stable(rsp_final_sample)))
      else $error("waiting result word changed");

endmodule

bind stft_overlap_add_synthesis_top istft_checker u_checker (.*);
`default_nettype wire

// ===== test/stft_overlap_add_synthesis_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Overlap-add synthesis regression
// Sends whole spectrum frames through the req_ queue and checks every sample
// popped from the rsp_ queue against a software predictor of the inverse
// transform, Hann window, overlap accumulator and output scaling. Hop size and
// output length are changed between frames while the block is idle.
// ----------------------------------------------------------------------------
module stft_overlap_add_synthesis_top_tb;
   import istft_pkg::*;

   localparam int SETTLE_CYCLES      = 70000;
   localparam int EMIT_SETTLE_CYCLES = 256;
   localparam int PARTIAL_BINS       = 23;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_push = 1'b0;
   logic               req_full;
   logic signed [31:0] req_bin_real = '0;
   logic signed [31:0] req_bin_imag = '0;
   logic               rsp_empty;
   logic               rsp_pop = 1'b0;
   logic signed [23:0] rsp_sample;
   logic               rsp_final_sample;
   logic               csr_wr_en = 1'b0;
   logic               csr_index = 1'b0;
   logic [31:0]        csr_wdata = '0;

   stft_overlap_add_synthesis_top dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state.
   longint      cos_rom [FFT_SIZE];
   longint      sin_rom [FFT_SIZE];
   longint      hann_rom [FFT_SIZE];
   longint      spec_re [NUM_BINS];
   longint      spec_im [NUM_BINS];
   int          overlap [FFT_SIZE];
   int unsigned bins_held;
   int unsigned frames_done;
   int unsigned samples_out;
   int unsigned hop_reg;
   int unsigned length_reg;
   int          last_frame_samples;

   out_item_type pending_samples [$];
   int           errors = 0;
   bit           steady = 1'b0;

   function automatic longint sine_q30(int a);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint sum;
      x = (64'd2 * PI_Q30 * 64'(a) + 64'(HALF_N)) / 64'(FFT_SIZE);
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int i = 1; i <= 8; i++) begin
         term = (term * x2) >> 30;
         term = term / 64'(2 * i * (2 * i + 1));
         if (i % 2 == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) sum = 0;
      if (sum > ONE_Q30) sum = ONE_Q30;
      return sum;
   endfunction

   function automatic longint round_shift(longint v, int sh);
      longint t;
      t = v + (64'sd1 <<< (sh - 1));
      if (t >= 0) return t >>> sh;
      return -(((-t) + (64'sd1 <<< sh) - 1) >>> sh);
   endfunction

   task automatic reset_predictor();
      longint mag [QUART_N+1];
      int r;
      longint cm;
      longint sm;
      longint cs;
      longint ss;
      for (int a = 0; a <= QUART_N; a++) mag[a] = sine_q30(a);
      for (int k = 0; k < FFT_SIZE; k++) begin
         r = k % QUART_N;
         case (k / QUART_N)
            0: begin cm = mag[QUART_N-r]; cs = 1;  sm = mag[r];         ss = 1;  end
            1: begin cm = mag[r];         cs = -1; sm = mag[QUART_N-r]; ss = 1;  end
            2: begin cm = mag[QUART_N-r]; cs = -1; sm = mag[r];         ss = -1; end
            default: begin cm = mag[r];   cs = 1;  sm = mag[QUART_N-r]; ss = -1; end
         endcase
         cos_rom[k] = cs * ((cm + 128) >>> 8);
         sin_rom[k] = ss * ((sm + 128) >>> 8);
         hann_rom[k] = (ONE_Q30 - cs * cm + 128) >>> 8;
         if (hann_rom[k] > 8388607) hann_rom[k] = 8388607;
         overlap[k] = 0;
      end
      for (int k = 0; k < NUM_BINS; k++) begin
         spec_re[k] = 0;
         spec_im[k] = 0;
      end
      bins_held = 0;
      frames_done = 0;
      samples_out = 0;
      hop_reg = 64;
      length_reg = 0;
      last_frame_samples = 0;
   endtask

   task automatic synthesise_frame(int unsigned base);
      longint s;
      longint nyq;
      longint x;
      longint y;
      longint t;
      int p;
      for (int n = 0; n < FFT_SIZE; n++) begin
         nyq = spec_re[HALF_N] * 4194304;
         s = spec_re[0] * 4194304 + ((n % 2 == 1) ? -nyq : nyq);
         for (int k = 1; k < HALF_N; k++) begin
            p = (k * n) % FFT_SIZE;
            s = s + 2 * (spec_re[k] * cos_rom[p] - spec_im[k] * sin_rom[p]);
         end
         x = round_shift(s, LOG2_N + 22);
         y = round_shift(x * hann_rom[n], 23);
         p = (base + n) % FFT_SIZE;
         t = longint'(overlap[p]) + y;
         if (t > 64'sd2147483647) t = 64'sd2147483647;
         if (t < -64'sd2147483648) t = -64'sd2147483648;
         overlap[p] = int'(t);
      end
   endtask

   task automatic absorb_bin(logic signed [31:0] re, logic signed [31:0] im);
      int unsigned hop;
      longint unsigned start;
      int unsigned base;
      longint a;
      longint o;
      out_item_type item;
      if (bins_held >= NUM_BINS) bins_held = 0;
      spec_re[bins_held] = longint'(re);
      spec_im[bins_held] = (bins_held == 0 || bins_held == HALF_N) ? 0 : longint'(im);
      bins_held++;
      if (bins_held < NUM_BINS) return;
      bins_held = 0;
      hop = (hop_reg == 0) ? 1 : ((hop_reg > 64) ? 64 : hop_reg);
      start = 64'(frames_done) * 64'(hop);
      base = int'(start % 64'(FFT_SIZE));
      synthesise_frame(base);
      last_frame_samples = 0;
      for (int j = 0; j < hop; j++) begin
         a = overlap[(base + j) % FFT_SIZE];
         overlap[(base + j) % FFT_SIZE] = 0;
         if (start + 64'(j) < 64'(HALF_N)) continue;
         if (samples_out >= length_reg) continue;
         a = 4 * a + 3;
         o = (a >= 0) ? a / 6 : -(((-a) + 5) / 6);
         if (o > 8388607) o = 8388607;
         if (o < -8388608) o = -8388608;
         item.sample = 24'(o);
         item.final_sample = (samples_out == length_reg - 1);
         pending_samples.push_back(item);
         samples_out++;
         last_frame_samples++;
      end
      frames_done++;
   endtask

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch: %s got %0d expected %0d", what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      rsp_pop <= steady ? 1'b1 : ($urandom_range(99) >= 17);
   end

   always @(posedge clock) begin
      out_item_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_samples.size() == 0) begin
            report_mismatch("unexpected sample", rsp_sample, 0);
         end else begin
            want = pending_samples.pop_front();
            if (rsp_sample !== want.sample)
               report_mismatch("sample", rsp_sample, want.sample);
            if (rsp_final_sample !== want.final_sample)
               report_mismatch("final_sample", rsp_final_sample, want.final_sample);
         end
      end
   end

   task automatic send_bin(logic signed [31:0] re, logic signed [31:0] im);
      req_push <= 1'b1;
      req_bin_real <= re;
      req_bin_imag <= im;
      do @(posedge clock); while (req_full);
      absorb_bin(re, im);
      if (!steady && $urandom_range(99) < 17) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   function automatic logic signed [31:0] random_bin();
      logic signed [31:0] v;
      v = $urandom;
      if ($urandom_range(2) == 0) return v;
      return v >>> $urandom_range(3, 14);
   endfunction

   task automatic send_random_frame();
      for (int k = 0; k < NUM_BINS; k++) send_bin(random_bin(), random_bin());
   endtask

   task automatic write_csr(logic idx, logic [31:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_HOP_SIZE) hop_reg = value & 32'h7f;
      else length_reg = value;
   endtask

   task automatic wait_idle();
      req_push <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      if (last_frame_samples == 0) repeat (SETTLE_CYCLES) @(posedge clock);
      else repeat (EMIT_SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_extreme_bins();
      logic signed [31:0] edge_re [8] = '{32'sh7fffffff, 32'sh80000000, 0, -1,
                                          32'sh7fffffff, 32'sh80000000, 1, 32'sh55555555};
      logic signed [31:0] edge_im [8] = '{32'sh7fffffff, 32'sh80000000, 0, -1,
                                          32'sh80000000, 32'sh7fffffff, -1, 32'shaaaaaaaa};
      write_csr(CSR_HOP_SIZE, 32'd64);
      write_csr(CSR_SIGNAL_LENGTH, 32'hffffffff);
      for (int k = 0; k < NUM_BINS; k++) begin
         if (k < 8) send_bin(edge_re[k], edge_im[k]);
         else if (k == HALF_N) send_bin(32'sh80000000, 32'sh7fffffff);
         else if (k < 20) send_bin(0, 0);
         else send_bin(random_bin(), random_bin());
      end
   endtask

   task automatic test_hop_limits();
      wait_idle();
      write_csr(CSR_HOP_SIZE, 32'd0);
      steady = 1'b1;
      send_random_frame();
      steady = 1'b0;
   endtask

   task automatic test_signal_end();
      wait_idle();
      write_csr(CSR_HOP_SIZE, 32'd100);
      write_csr(CSR_SIGNAL_LENGTH, 32'd40);
      send_random_frame();
      // Hold further bins back until every finished sample has drained.
      wait_idle();
   endtask

   task automatic test_partial_frame();
      for (int k = 0; k < PARTIAL_BINS; k++) send_bin(random_bin(), random_bin());
   endtask

   initial begin
      reset_predictor();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extreme_bins();
      test_hop_limits();
      test_signal_end();
      test_partial_frame();
      req_push <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("stft_overlap_add_synthesis_top regression: pass");
      end else begin
         $display("stft_overlap_add_synthesis_top regression: fail");
      end
      $finish;
   end

   initial begin
      #60_000_000;
      $display("stft_overlap_add_synthesis_top regression: fail");
      $finish;
   end

endmodule
